// ----- rtl/ipru_pkg.sv -----
// Shared constants, types and helper functions for the pixel replication upscaler.
package ipru_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_SCALE  = 100;
    localparam int SCALE_W    = 7;
    localparam int WIDTH_W    = 11;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int FILL_W     = $clog2(MAX_WIDTH + 1);
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        KIND_ACCEPT    = 3'd0,
        KIND_REFUSE    = 3'd1,
        KIND_PIXEL     = 3'd2,
        KIND_PAD       = 3'd3,
        KIND_NOT_READY = 3'd4
    } kind_t;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_PULL = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_SCALE = 1'b0,
        REG_WIDTH = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        kind_t kind;
        logic  row_last;
    } step_res_t;

    function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
        logic [SCALE_W-1:0] r;
        if (s == '0) begin
            r = SCALE_W'(1);
        end else if (s > SCALE_W'(MAX_SCALE)) begin
            r = SCALE_W'(MAX_SCALE);
        end else begin
            r = s;
        end
        return r;
    endfunction

    function automatic logic [FILL_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
        logic [FILL_W-1:0] r;
        if (w == '0) begin
            r = FILL_W'(1);
        end else if (FILL_W'(w) > FILL_W'(MAX_WIDTH)) begin
            r = FILL_W'(MAX_WIDTH);
        end else begin
            r = FILL_W'(w);
        end
        return r;
    endfunction

endpackage

// ----- rtl/ipru_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module ipru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/ipru_cfg.sv -----
// APB-style register file holding the scale factor and the row width.
module ipru_cfg
    import ipru_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [SCALE_W-1:0]    scale_factor,
    output logic [WIDTH_W-1:0]    row_width
);

    logic [SCALE_W-1:0] scale_reg;
    logic [WIDTH_W-1:0] width_reg;
    reg_idx_t           idx;
    logic               wr_strobe;

    // Registers sit on word boundaries, so the word index picks the register.
    assign idx       = reg_idx_t'(paddr[2]);
    assign wr_strobe = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_W'(1);
            width_reg <= WIDTH_W'(1);
        end else if (wr_strobe) begin
            unique case (idx)
                REG_SCALE: scale_reg <= pwdata[SCALE_W-1:0];
                REG_WIDTH: width_reg <= pwdata[WIDTH_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SCALE: prdata = APB_DATA_W'(scale_reg);
            REG_WIDTH: prdata = APB_DATA_W'(width_reg);
            default:   prdata = '0;
        endcase
    end

    assign scale_factor = scale_reg;
    assign row_width    = width_reg;

endmodule

// ----- rtl/ipru_ctrl.sv -----
// Fill and replay sequencer: decides each beat's result and drives the line store.
module ipru_ctrl
    import ipru_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  cmd_t               cmd,
    input  logic [SCALE_W-1:0] scale_factor,
    input  logic [WIDTH_W-1:0] row_width,
    output step_res_t          res,
    output mem_req_t           req
);

    logic [FILL_W-1:0]  fill_count_reg,    fill_count_next;
    logic               replaying_reg,     replaying_next;
    logic [SCALE_W-1:0] row_copy_reg,      row_copy_next;
    logic [ADDR_W-1:0]  source_column_reg, source_column_next;
    logic [SCALE_W-1:0] repeat_index_reg,  repeat_index_next;
    logic [1:0]         pad_remaining_reg, pad_remaining_next;

    logic [SCALE_W-1:0] eff_s;
    logic [FILL_W-1:0]  eff_w;
    logic [ADDR_W-1:0]  push_idx;
    logic [3:0]         pad_prod;
    logic               finish_row;

    assign eff_s    = eff_scale(scale_factor);
    assign eff_w    = eff_width(row_width);
    assign pad_prod = {2'b00, eff_w[1:0]} * {2'b00, eff_s[1:0]};

    always_comb begin
        fill_count_next    = fill_count_reg;
        replaying_next     = replaying_reg;
        row_copy_next      = row_copy_reg;
        source_column_next = source_column_reg;
        repeat_index_next  = repeat_index_reg;
        pad_remaining_next = pad_remaining_reg;
        finish_row         = 1'b0;
        res.kind           = KIND_NOT_READY;
        res.row_last       = 1'b0;

        push_idx = (fill_count_reg >= FILL_W'(MAX_WIDTH)) ? ADDR_W'(MAX_WIDTH - 1)
                                                          : fill_count_reg[ADDR_W-1:0];
        req.wr_en   = 1'b0;
        req.wr_addr = push_idx;
        req.rd_en   = 1'b0;
        req.rd_addr = source_column_reg;

        if (cmd == CMD_PUSH) begin
            if (replaying_reg) begin
                res.kind = KIND_REFUSE;
            end else begin
                res.kind        = KIND_ACCEPT;
                req.wr_en       = accept;
                fill_count_next = FILL_W'(push_idx) + FILL_W'(1);
                if (FILL_W'(push_idx) + FILL_W'(1) >= eff_w) begin
                    replaying_next     = 1'b1;
                    row_copy_next      = '0;
                    source_column_next = '0;
                    repeat_index_next  = '0;
                    pad_remaining_next = '0;
                end
            end
        end else if (!replaying_reg) begin
            res.kind = KIND_NOT_READY;
        end else if (pad_remaining_reg != 2'd0) begin
            res.kind           = KIND_PAD;
            pad_remaining_next = pad_remaining_reg - 2'd1;
            if (pad_remaining_reg == 2'd1) begin
                res.row_last = 1'b1;
                finish_row   = 1'b1;
            end
        end else begin
            res.kind  = KIND_PIXEL;
            req.rd_en = accept;
            if ({1'b0, repeat_index_reg} + 1'b1 >= {1'b0, eff_s}) begin
                repeat_index_next = '0;
                if (FILL_W'(source_column_reg) + FILL_W'(1) >= eff_w) begin
                    if (pad_prod[1:0] == 2'd0) begin
                        res.row_last = 1'b1;
                        finish_row   = 1'b1;
                    end else begin
                        pad_remaining_next = pad_prod[1:0];
                    end
                end else begin
                    source_column_next = source_column_reg + 1'b1;
                end
            end else begin
                repeat_index_next = repeat_index_reg + 1'b1;
            end
        end

        // End of an output row: either start the next copy or release the store.
        if (finish_row) begin
            source_column_next = '0;
            repeat_index_next  = '0;
            pad_remaining_next = '0;
            if ({1'b0, row_copy_reg} + 1'b1 >= {1'b0, eff_s}) begin
                row_copy_next   = '0;
                replaying_next  = 1'b0;
                fill_count_next = '0;
            end else begin
                row_copy_next = row_copy_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg    <= '0;
            replaying_reg     <= 1'b0;
            row_copy_reg      <= '0;
            source_column_reg <= '0;
            repeat_index_reg  <= '0;
            pad_remaining_reg <= '0;
        end else if (accept) begin
            fill_count_reg    <= fill_count_next;
            replaying_reg     <= replaying_next;
            row_copy_reg      <= row_copy_next;
            source_column_reg <= source_column_next;
            repeat_index_reg  <= repeat_index_next;
            pad_remaining_reg <= pad_remaining_next;
        end
    end

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.wr_en && req.rd_en))
        else $error("line store written and read by the same beat");

    a_pad_in_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        (pad_remaining_reg != 2'd0) |-> replaying_reg)
        else $error("pad bytes pending outside replay");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= FILL_W'(MAX_WIDTH))
        else $error("fill count beyond line store depth");

endmodule

// ----- rtl/integer_pixel_replication_upscaler.sv -----
// Top level of the integer pixel replication upscaler with its output pipeline.
//
// This block upscales 24-bit pixel rows by a whole factor. A push beat (cmd 0)
// writes one source pixel into a single-row line store; once row_width pixels are
// held, pull beats (cmd 1) return each pixel scale_factor times, followed by zero
// pad bytes that round the output row to a multiple of four bytes, and the whole
// row is replayed scale_factor times before the store accepts a new row. Every
// input beat yields exactly one result beat: push accepted, push refused, pixel,
// pad byte or not ready. The block takes one beat per clock cycle in steady state,
// and the result of each accepted input beat is registered in the middle stage,
// which lines up with the line store's registered read port, and then in the
// output register. While a finished result waits for m_ready, the stage in front
// of the output register can still take one more input beat; after that s_ready
// stays low until the output register empties.
// The line store has no clearing pass, so the block is ready straight after
// reset. Registers are scale_factor at byte address 0 and row_width at byte
// address 4; they should be written only while the block is idle, and
// out-of-range values are clamped.
module integer_pixel_replication_upscaler
    import ipru_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [CH_W-1:0]       s_red_in,
    input  logic [CH_W-1:0]       s_green_in,
    input  logic [CH_W-1:0]       s_blue_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_kind,
    output logic [CH_W-1:0]       m_red_out,
    output logic [CH_W-1:0]       m_green_out,
    output logic [CH_W-1:0]       m_blue_out,
    output logic                  m_row_last
);

    logic [SCALE_W-1:0] scale_factor;
    logic [WIDTH_W-1:0] row_width;
    step_res_t          res;
    mem_req_t           req;
    logic [PIX_W-1:0]   rd_data;
    logic               accept;
    logic               out_free;

    // Middle stage: the line store's read data lines up with this stage.
    logic               b_valid_reg;
    kind_t              b_kind_reg;
    logic               b_last_reg;

    // Output register.
    logic               m_valid_reg;
    kind_t              m_kind_reg;
    logic [PIX_W-1:0]   m_pix_reg;
    logic               m_last_reg;
    logic [PIX_W-1:0]   m_pix_next;

    ipru_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .scale_factor (scale_factor),
        .row_width    (row_width)
    );

    // The output register is free when empty or being emptied this cycle; the
    // middle stage may then move on, and so a new beat can come in behind it.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !b_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    ipru_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .cmd          (cmd_t'(s_cmd)),
        .scale_factor (scale_factor),
        .row_width    (row_width),
        .res          (res),
        .req          (req)
    );

    // Reads are issued only with an accepted pixel beat, so the read data holds
    // steady while that beat waits in the middle stage.
    ipru_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data ({s_red_in, s_green_in, s_blue_in}),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (rd_data)
    );

    // Only pixel results carry colour; every other kind reports zero bytes.
    assign m_pix_next = (b_kind_reg == KIND_PIXEL) ? rd_data : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                b_valid_reg <= accept;
            end
            if (out_free) begin
                m_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_kind_reg <= res.kind;
            b_last_reg <= res.row_last;
        end
        if (out_free && b_valid_reg) begin
            m_kind_reg <= b_kind_reg;
            m_pix_reg  <= m_pix_next;
            m_last_reg <= b_last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_red_out   = m_pix_reg[PIX_W-1 -: CH_W];
    assign m_green_out = m_pix_reg[CH_W +: CH_W];
    assign m_blue_out  = m_pix_reg[CH_W-1:0];
    assign m_row_last  = m_last_reg;

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !out_free) |-> !s_ready)
        else $error("input taken while the middle stage is blocked");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the integer pixel replication upscaler.
module tb;
    import ipru_pkg::*;

    // One result beat as the block should present it.
    typedef struct packed {
        kind_t           kind;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            row_last;
    } upscale_beat_t;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic                  s_valid    = 1'b0;
    logic                  s_cmd      = CMD_PUSH;
    logic [CH_W-1:0]       s_red_in   = '0;
    logic [CH_W-1:0]       s_green_in = '0;
    logic [CH_W-1:0]       s_blue_in  = '0;
    logic                  m_ready    = 1'b0;

    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_ready;
    logic                  m_valid;
    logic [2:0]            m_kind;
    logic [CH_W-1:0]       m_red_out;
    logic [CH_W-1:0]       m_green_out;
    logic [CH_W-1:0]       m_blue_out;
    logic                  m_row_last;

    // Shadow of the block: configuration, line store and replay position.
    logic [SCALE_W-1:0] cfg_scale;
    logic [WIDTH_W-1:0] cfg_width;
    logic [PIX_W-1:0]   row_pixels [MAX_WIDTH];
    logic [FILL_W-1:0]  fill_count;
    logic               replay_on;
    logic [SCALE_W-1:0] copy_index;
    logic [ADDR_W-1:0]  column_index;
    logic [SCALE_W-1:0] repeat_count;
    logic [1:0]         pads_left;
    // Highest number of store entries ever written. Entries are always filled from
    // address zero upwards, so every entry below this count holds a real pixel.
    logic [FILL_W-1:0]  entries_written;

    // Results still owed by the block, oldest first.
    upscale_beat_t owed_beats [$];

    int unsigned mismatches    = 0;
    int unsigned beats_offered = 0;
    int unsigned tx_idle_pct   = 0;
    int unsigned rx_idle_pct   = 0;
    // A long receiver hold-off is requested here and then counted down by the
    // receiver process itself.
    int unsigned hold_request  = 0;
    int unsigned hold_left     = 0;

    integer_pixel_replication_upscaler u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_row_last  (m_row_last)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // The registers are clamped when used: zero acts as one, and values above the
    // line store's size or the largest factor act as that limit.
    function automatic int unsigned scale_in_use();
        if (cfg_scale == 0) return 1;
        if (cfg_scale > MAX_SCALE) return MAX_SCALE;
        return cfg_scale;
    endfunction

    function automatic int unsigned width_in_use();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    // After the last element of an output row the position returns to the row
    // start; once every copy of the row has gone out, the store takes a new row.
    task automatic close_output_row();
        column_index = '0;
        repeat_count = '0;
        pads_left    = '0;
        if (copy_index + 1 >= scale_in_use()) begin
            copy_index = '0;
            replay_on  = 1'b0;
            fill_count = '0;
        end else begin
            copy_index = copy_index + 1'b1;
        end
    endtask

    // Works out the result of one accepted beat and advances the shadow state.
    // Every end test is "reached or passed", so registers changed in the middle
    // of a row take effect at the first element that meets the new bound.
    task automatic predict_upscaled_beat(input cmd_t cmd, input logic [CH_W-1:0] red,
                                         input logic [CH_W-1:0] green,
                                         input logic [CH_W-1:0] blue,
                                         output upscale_beat_t res);
        int unsigned idx;
        int unsigned col;
        int unsigned pads;
        res = '{kind: KIND_ACCEPT, red: '0, green: '0, blue: '0, row_last: 1'b0};
        if (cmd == CMD_PUSH) begin
            if (replay_on) begin
                res.kind = KIND_REFUSE;
            end else begin
                idx = fill_count;
                if (idx >= MAX_WIDTH) idx = MAX_WIDTH - 1;
                row_pixels[idx] = {red, green, blue};
                if (idx + 1 > entries_written) entries_written = FILL_W'(idx + 1);
                fill_count = FILL_W'(idx + 1);
                if (idx + 1 >= width_in_use()) begin
                    replay_on    = 1'b1;
                    copy_index   = '0;
                    column_index = '0;
                    repeat_count = '0;
                    pads_left    = '0;
                end
            end
        end else if (!replay_on) begin
            res.kind = KIND_NOT_READY;
        end else if (pads_left != 0) begin
            // Pad bytes are zero; the last one closes the output row.
            res.kind  = KIND_PAD;
            pads_left = pads_left - 1'b1;
            if (pads_left == 0) begin
                res.row_last = 1'b1;
                close_output_row();
            end
        end else begin
            col = column_index;
            if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;
            {res.red, res.green, res.blue} = row_pixels[col];
            res.kind = KIND_PIXEL;
            if (repeat_count + 1 >= scale_in_use()) begin
                repeat_count = '0;
                if (col + 1 >= width_in_use()) begin
                    // The pad count is taken from the registers as they stand now.
                    pads = (width_in_use() * scale_in_use()) % 4;
                    if (pads == 0) begin
                        res.row_last = 1'b1;
                        close_output_row();
                    end else begin
                        pads_left = 2'(pads);
                    end
                end else begin
                    column_index = ADDR_W'(col + 1);
                end
            end else begin
                repeat_count = repeat_count + 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    function automatic void report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // Each accepted result beat is compared with the oldest owed result. Values
    // are sampled just after the edge, before any of this edge's updates land.
    always @(posedge aclk) begin
        upscale_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_beats.size() == 0) begin
                report_mismatch($sformatf(
                    {"result beat with none owed: ",
                     "kind %0d rgb %02h%02h%02h last %0b"},
                    m_kind, m_red_out, m_green_out, m_blue_out, m_row_last));
            end else begin
                want = owed_beats.pop_front();
                if (m_kind !== want.kind || m_red_out !== want.red ||
                    m_green_out !== want.green || m_blue_out !== want.blue ||
                    m_row_last !== want.row_last) begin
                    report_mismatch($sformatf(
                        {"expected kind %0d rgb %02h%02h%02h last %0b, ",
                         "got kind %0d rgb %02h%02h%02h last %0b"},
                        want.kind, want.red, want.green, want.blue, want.row_last,
                        m_kind, m_red_out, m_green_out, m_blue_out, m_row_last));
                end
            end
        end
    end

    // Receiver: random stalls at the current rate, or a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offers one beat after a random number of idle cycles and holds it until the
    // block takes it. The owed result is recorded at the accepting edge.
    task automatic offer_beat(input cmd_t cmd, input logic [CH_W-1:0] red,
                              input logic [CH_W-1:0] green, input logic [CH_W-1:0] blue);
        upscale_beat_t res;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_red_in   <= red;
        s_green_in <= green;
        s_blue_in  <= blue;
        do @(posedge aclk); while (!s_ready);
        predict_upscaled_beat(cmd, red, green, blue, res);
        owed_beats.push_back(res);
        beats_offered++;
    endtask

    // A beat with random colours; with the given chance the command is random too,
    // which gives refused pushes during replay and not-ready pulls during filling.
    task automatic offer_random(input cmd_t cmd, input int unsigned noise_pct);
        cmd_t pick;
        pick = cmd;
        if ($urandom_range(0, 99) < noise_pct) pick = cmd_t'($urandom_range(0, 1));
        offer_beat(pick, CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                   CH_W'($urandom_range(0, 255)));
    endtask

    task automatic fill_row(input int unsigned noise_pct);
        while (!replay_on) offer_random(CMD_PUSH, noise_pct);
    endtask

    task automatic finish_replay(input int unsigned noise_pct);
        while (replay_on) offer_random(CMD_PULL, noise_pct);
    endtask

    // The sender rests until every owed result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (owed_beats.size() != 0);
    endtask

    // Writes a register, then reads it back in the next transfer. Only called with
    // nothing owed, so the block is idle.
    task automatic cfg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_SCALE) begin
            cfg_scale = value[SCALE_W-1:0];
            readback  = APB_DATA_W'(value[SCALE_W-1:0]);
        end else begin
            cfg_width = value[WIDTH_W-1:0];
            readback  = APB_DATA_W'(value[WIDTH_W-1:0]);
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== readback)
            report_mismatch($sformatf("register %0d read back %0h, expected %0h",
                                      idx, prdata, readback));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings (factor one, one pixel per row): every result kind, the
    // extreme colour values, and the single pad byte that one pixel needs.
    task automatic test_reset_defaults();
        offer_beat(CMD_PULL, 8'hFF, 8'hFF, 8'hFF);  // not ready, nothing stored
        offer_beat(CMD_PUSH, 8'hFF, 8'h00, 8'hFF);  // completes the row
        offer_beat(CMD_PUSH, 8'h00, 8'hFF, 8'h00);  // refused during replay
        offer_beat(CMD_PULL, 8'h00, 8'h00, 8'h00);  // pixel
        offer_beat(CMD_PULL, 8'h00, 8'h00, 8'h00);  // pad byte, end of row
        offer_beat(CMD_PUSH, 8'h00, 8'h00, 8'h00);
        offer_beat(CMD_PULL, 8'hFF, 8'h00, 8'hFF);
        offer_beat(CMD_PULL, 8'hFF, 8'h00, 8'hFF);
        offer_beat(CMD_PUSH, 8'hFF, 8'hFF, 8'hFF);
        offer_beat(CMD_PUSH, 8'h00, 8'h00, 8'h00);
        offer_beat(CMD_PULL, 8'h5A, 8'hA5, 8'h3C);
        offer_beat(CMD_PULL, 8'hC3, 8'h69, 8'h96);
        offer_beat(CMD_PUSH, 8'h00, 8'hFF, 8'hFF);
        finish_replay(0);
        offer_beat(CMD_PULL, 8'h12, 8'h34, 8'h56);
        wait_drained();
    endtask

    // Zero in either register acts as one.
    task automatic test_clamp_low();
        cfg_write(REG_SCALE, 0);
        cfg_write(REG_WIDTH, 0);
        fill_row(0);
        offer_random(CMD_PUSH, 0);
        finish_replay(0);
        wait_drained();
    endtask

    // The width is lowered while the row fills, so the next push completes it;
    // during replay it is raised again, but only over entries already written.
    task automatic test_width_change_mid_row();
        cfg_write(REG_SCALE, 2);
        cfg_write(REG_WIDTH, 6);
        repeat (3) offer_random(CMD_PUSH, 0);
        wait_drained();
        cfg_write(REG_WIDTH, 2);
        offer_random(CMD_PUSH, 0);
        repeat (3) offer_random(CMD_PULL, 0);
        wait_drained();
        cfg_write(REG_WIDTH, 4);
        finish_replay(0);
        wait_drained();
    endtask

    // A factor above the largest acts as the largest. Part way into the second
    // output row the factor drops to one, which ends the replay with that row.
    task automatic test_scale_clamp_high();
        cfg_write(REG_SCALE, 127);
        cfg_write(REG_WIDTH, 1);
        fill_row(0);
        repeat (130) offer_random(CMD_PULL, 0);
        wait_drained();
        cfg_write(REG_SCALE, 1);
        finish_replay(0);
        wait_drained();
    endtask

    // A width above the line store's size acts as the full store, so a short row
    // stays in filling; the width then drops to the fill count, and the next
    // push completes the row.
    task automatic test_full_width_row();
        cfg_write(REG_SCALE, 1);
        cfg_write(REG_WIDTH, 2047);
        repeat (20) offer_random(CMD_PUSH, 0);
        wait_drained();
        cfg_write(REG_WIDTH, 20);
        offer_random(CMD_PUSH, 0);
        finish_replay(0);
        wait_drained();
        cfg_write(REG_WIDTH, MAX_WIDTH);
        cfg_write(REG_SCALE, MAX_SCALE);
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while pulls keep coming, so the
    // block fills up and stalls its input. Then the sender waits for everything.
    task automatic test_output_stall();
        cfg_write(REG_SCALE, MAX_SCALE);
        cfg_write(REG_WIDTH, 3);
        fill_row(0);
        hold_request = 300;
        repeat (80) offer_random(CMD_PULL, 0);
        wait_drained();
        cfg_write(REG_SCALE, 1);
        finish_replay(0);
        wait_drained();
    endtask

    // Changes one register in the middle of a replay. A raised width never goes
    // beyond the entries that have been written.
    task automatic retune_mid_replay();
        int unsigned limit;
        wait_drained();
        if ($urandom_range(0, 1) == 0) begin
            cfg_write(REG_SCALE, $urandom_range(1, 4));
        end else begin
            limit = (entries_written < 8) ? entries_written : 8;
            cfg_write(REG_WIDTH, $urandom_range(1, limit));
        end
    endtask

    // One well-formed row with random content and some noise; now and then one
    // register is changed part way through the replay.
    task automatic run_random_row();
        int unsigned stop_at;
        int unsigned pulls;
        fill_row(10);
        stop_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
        pulls   = 0;
        while (replay_on) begin
            offer_random(CMD_PULL, 10);
            pulls++;
            if (pulls == stop_at && replay_on) retune_mid_replay();
        end
    endtask

    // Random rows under three idling patterns: sender idles more lightly than the
    // receiver, then the reverse, then neither idles.
    task automatic test_random_rows();
        int unsigned tx_pct [3] = '{30, 51, 0};
        int unsigned rx_pct [3] = '{51, 30, 0};
        int unsigned goal;
        int          mode;
        for (mode = 0; mode < 3; mode++) begin
            tx_idle_pct = tx_pct[mode];
            rx_idle_pct = rx_pct[mode];
            goal = beats_offered + 70;
            while (beats_offered < goal) begin
                wait_drained();
                cfg_write(REG_SCALE, ($urandom_range(0, 9) == 0) ? 0 :
                          $urandom_range(1, ($urandom_range(0, 4) == 0) ? 7 : 4));
                cfg_write(REG_WIDTH, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
                repeat ($urandom_range(1, 2)) run_random_row();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        // The shadow starts in the block's reset state.
        cfg_scale       = SCALE_W'(1);
        cfg_width       = WIDTH_W'(1);
        fill_count      = '0;
        replay_on       = 1'b0;
        copy_index      = '0;
        column_index    = '0;
        repeat_count    = '0;
        pads_left       = '0;
        entries_written = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 30;
        rx_idle_pct = 51;
        test_reset_defaults();
        test_clamp_low();
        test_width_change_mid_row();
        test_scale_clamp_high();
        test_full_width_row();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_output_stall();
        test_random_rows();

        // Everything has been answered; a few more cycles catch any stray beat.
        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("integer_pixel_replication_upscaler regression: pass");
        end else begin
            $display("integer_pixel_replication_upscaler regression: fail");
        end
        $finish;
    end

    // Far beyond the slowest correct run; reaching it means the block hung.
    initial begin
        #5000000;
        $display("integer_pixel_replication_upscaler regression: fail");
        $finish;
    end

endmodule
